// File: rtl/core/ldd_pkg.sv
// shared types, sizes and codes for the lock deadlock detector
package ldd_pkg;

  localparam int THREADS = 16;
  localparam int MUTEXES = 16;

  localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int MW = (MUTEXES > 1) ? $clog2(MUTEXES) : 1;
  localparam int SW = $clog2(THREADS + 1);

  typedef enum logic [1:0] {
    REQ_LOCK     = 2'd0,
    REQ_ACQUIRED = 2'd1,
    REQ_UNLOCK   = 2'd2
  } ldd_req_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] thread_id;
    logic [3:0] mutex_id;
  } ldd_in_t;

  typedef struct packed {
    logic       deadlock;
    logic [4:0] chain_threads;
    logic [4:0] chain_mutexes;
    logic       walk_limit_hit;
  } ldd_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WALK,
    ST_UPDATE
  } ldd_state_t;

  typedef struct packed {
    logic load_in;
    logic load_owner;
    logic step;
    logic update;
  } ldd_cmd_t;

  typedef struct packed {
    logic walk_req;
    logic owner_found;
    logic walk_stop;
  } ldd_status_t;

endpackage

// File: rtl/core/ldd_ctrl.sv
// sequencer for the lock deadlock detector: load, walk, table update
module ldd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  output ldd_pkg::ldd_cmd_t   cmd,
  input  ldd_pkg::ldd_status_t status
);
  import ldd_pkg::*;

  ldd_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = 1'b0;
    cmd            = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_owner = 1'b1;
        if (status.walk_req && status.owner_found) begin
          state_nxt = ST_WALK;
        end else begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (status.walk_stop) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/ldd_datapath.sv
// owner and wait tables, chain walker and result registers
module ldd_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ldd_pkg::ldd_in_t     in_item,
  input  ldd_pkg::ldd_cmd_t    cmd,
  output ldd_pkg::ldd_status_t status,
  output ldd_pkg::ldd_out_t    out_item
);
  import ldd_pkg::*;

  // tables with separate valid flags
  logic [TW-1:0] owner_r      [MUTEXES];
  logic          owner_vld_r  [MUTEXES];
  logic [MW-1:0] wait_r       [THREADS];
  logic          wait_vld_r   [THREADS];

  // latched word
  logic [1:0]    req_r;
  logic [TW-1:0] t_r;
  logic [MW-1:0] m_r;
  logic          ok_r;

  // walk state
  logic [TW-1:0] cur_r;
  logic [SW-1:0] steps_r;
  logic [SW-1:0] mutexes_r;
  logic          dead_r;
  logic          capped_r;

  logic          in_ok;
  logic [MW-1:0] nm;
  logic [MW-1:0] own_addr;
  logic [TW-1:0] own_rd;
  logic          own_vld_rd;
  logic          hit;
  logic          wv;
  logic          at_cap;

  assign in_ok = (int'(in_item.thread_id) < THREADS) && (int'(in_item.mutex_id) < MUTEXES);

  // single read port on each table
  assign nm         = wait_r[cur_r];
  assign wv         = wait_vld_r[cur_r];
  assign own_addr   = cmd.load_owner ? m_r : nm;
  assign own_rd     = owner_r[own_addr];
  assign own_vld_rd = owner_vld_r[own_addr];
  assign hit        = (cur_r == t_r);
  assign at_cap     = (steps_r == SW'(THREADS - 1));

  assign status.walk_req    = ok_r && (req_r == REQ_LOCK);
  assign status.owner_found = own_vld_rd;
  assign status.walk_stop   = hit || !wv || at_cap || !own_vld_rd;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r     <= in_item.req_type;
      t_r       <= TW'(in_item.thread_id);
      m_r       <= MW'(in_item.mutex_id);
      ok_r      <= in_ok;
      steps_r   <= '0;
      mutexes_r <= (in_ok && (in_item.req_type == REQ_LOCK)) ? SW'(1) : '0;
      dead_r    <= 1'b0;
      capped_r  <= 1'b0;
    end
    if (cmd.load_owner) begin
      cur_r <= own_rd;
    end
    if (cmd.step) begin
      steps_r <= steps_r + SW'(1);
      if (hit) begin
        dead_r <= 1'b1;
      end else if (wv && at_cap) begin
        capped_r <= 1'b1;
      end else if (wv) begin
        mutexes_r <= mutexes_r + SW'(1);
        cur_r     <= own_rd;
      end
    end
  end

  // table valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MUTEXES; i++) owner_vld_r[i] <= 1'b0;
      for (int i = 0; i < THREADS; i++) wait_vld_r[i] <= 1'b0;
    end else if (cmd.update && ok_r) begin
      case (req_r)
        REQ_LOCK: begin
          wait_vld_r[t_r] <= 1'b1;
        end
        REQ_ACQUIRED: begin
          wait_vld_r[t_r]  <= 1'b0;
          owner_vld_r[m_r] <= 1'b1;
        end
        REQ_UNLOCK: begin
          owner_vld_r[m_r] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // table contents
  always_ff @(posedge clk) begin
    if (cmd.update && ok_r) begin
      case (req_r)
        REQ_LOCK: begin
          wait_r[t_r] <= m_r;
        end
        REQ_ACQUIRED: begin
          owner_r[m_r] <= t_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_item.deadlock       = dead_r;
  assign out_item.chain_threads  = 5'(steps_r);
  assign out_item.chain_mutexes  = 5'(mutexes_r);
  assign out_item.walk_limit_hit = capped_r;

endmodule

// File: rtl/core/lock_deadlock_detector.sv
// top level of the lock deadlock detector
// Every word taken (start high while busy is low) yields exactly one result, shown for one
// cycle with out_valid; the receiver cannot stall it. A lock request on an owned mutex walks
// the wait-for chain one thread per cycle through the owner and wait tables, between a load
// step and a table update step, and the result appears in the cycle in which busy falls. Lock
// acquired, unlock and ignored words skip the walk: a load step, then a table update step.
// Both tables read as empty straight after reset, with no clearing pass.
module lock_deadlock_detector (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ldd_pkg::ldd_in_t  in_item,
  output logic              out_valid,
  output ldd_pkg::ldd_out_t out_item
);
  import ldd_pkg::*;

  ldd_cmd_t    cmd;
  ldd_status_t status;

  ldd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .status    (status)
  );

  ldd_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

endmodule
